// ===== rtl/lir_pkg.sv =====
// shared types and constants for the longest increasing run finder
// beat payload structs, field widths, sequencer state encoding
// no dependencies
package lir_pkg;

   // default sizing of the block
   localparam int MAX_LEN_DEF  = 4096;
   localparam int MAX_RUNS_DEF = 32;

   // fixed field widths of the input and result beats
   localparam int VALUE_W     = 32;
   localparam int RUN_START_W = 12;
   localparam int BEST_LEN_W  = 13;
   localparam int RUN_COUNT_W = 6;

   // input beat
   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      last_of_sequence;
   } req_type;

   // result beat
   typedef struct packed {
      logic [RUN_START_W-1:0] run_start;
      logic [BEST_LEN_W-1:0]  best_length;
      logic [RUN_COUNT_W-1:0] run_count;
      logic                   ties_dropped;
      logic                   last_run;
   } rsp_type;

   // sequencer states
   typedef enum logic [1:0] {
      S_ACCUM,
      S_READ,
      S_SHOW
   } state_type;

endpackage

// ===== rtl/lir_tracker.sv =====
// run tracking for the longest increasing run finder
// follows the current run, the best length and the tie count; issues list writes
// depends on lir_pkg
module lir_tracker #(
   parameter int MAX_LEN  = lir_pkg::MAX_LEN_DEF,
   parameter int MAX_RUNS = lir_pkg::MAX_RUNS_DEF
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         take,
   input  logic signed [lir_pkg::VALUE_W-1:0]           value,
   input  logic                                         clear,
   output logic                                         wr_en,
   output logic [((MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1)-1:0] wr_addr,
   output logic [$clog2(MAX_LEN)-1:0]                   wr_data,
   output logic [$clog2(MAX_LEN+1)-1:0]                 longest,
   output logic [$clog2(MAX_RUNS+1)-1:0]                count,
   output logic                                         overflow
);

   localparam int PW = $clog2(MAX_LEN);
   localparam int LW = $clog2(MAX_LEN+1);
   localparam int CW = $clog2(MAX_RUNS+1);
   localparam int AW = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;

   logic signed [lir_pkg::VALUE_W-1:0] prev_ff, prev_in;
   logic [PW-1:0]                      pos_ff, pos_in;
   logic [LW-1:0]                      cur_ff, cur_in;
   logic [LW-1:0]                      lng_ff, lng_in;
   logic [CW-1:0]                      cnt_ff, cnt_in;
   logic                               ovf_ff, ovf_in;
   logic                               full_ff, full_in;
   logic                               up;
   logic [LW-1:0]                      cur_next;
   logic [PW-1:0]                      start;

   // run state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
         pos_ff  <= '0;
         cur_ff  <= LW'(1);
         lng_ff  <= LW'(1);
         cnt_ff  <= '0;
         ovf_ff  <= 1'b0;
         full_ff <= 1'b0;
      end else begin
         prev_ff <= prev_in;
         pos_ff  <= pos_in;
         cur_ff  <= cur_in;
         lng_ff  <= lng_in;
         cnt_ff  <= cnt_in;
         ovf_ff  <= ovf_in;
         full_ff <= full_in;
      end
   end

   // one element per beat: compare, extend or restart the run, replace the list or record ties; clear resets
   always_comb begin
      prev_in  = prev_ff;
      pos_in   = pos_ff;
      cur_in   = cur_ff;
      lng_in   = lng_ff;
      cnt_in   = cnt_ff;
      ovf_in   = ovf_ff;
      full_in  = full_ff;
      wr_en    = 1'b0;
      wr_addr  = '0;
      wr_data  = '0;
      up       = value > prev_ff;
      cur_next = up ? cur_ff + LW'(1) : LW'(1);
      start    = PW'(LW'(pos_ff) + LW'(1) - cur_next);
      if (clear) begin
         prev_in = '0;
         pos_in  = '0;
         cur_in  = LW'(1);
         lng_in  = LW'(1);
         cnt_in  = '0;
         ovf_in  = 1'b0;
         full_in = 1'b0;
      end else if (take && !full_ff) begin
         if (pos_ff == '0) begin
            // first element opens the only recorded run
            cur_in  = LW'(1);
            lng_in  = LW'(1);
            cnt_in  = CW'(1);
            ovf_in  = 1'b0;
            wr_en   = 1'b1;
         end else begin
            cur_in = cur_next;
            if (cur_next > lng_ff) begin
               // longer run replaces the list
               lng_in  = cur_next;
               cnt_in  = CW'(1);
               ovf_in  = 1'b0;
               wr_en   = 1'b1;
               wr_data = start;
            end else if (cur_next == lng_ff) begin
               if (cnt_ff < CW'(MAX_RUNS)) begin
                  cnt_in  = cnt_ff + CW'(1);
                  wr_en   = 1'b1;
                  wr_addr = cnt_ff[AW-1:0];
                  wr_data = start;
               end else begin
                  ovf_in = 1'b1;
               end
            end
         end
         prev_in = value;
         if (pos_ff == PW'(MAX_LEN - 1)) begin
            full_in = 1'b1;
         end else begin
            pos_in = pos_ff + PW'(1);
         end
      end
   end

   assign longest  = lng_ff;
   assign count    = cnt_ff;
   assign overflow = ovf_ff;

   // best length never falls below the current run
   a_cur_le_lng: assert property (@(posedge clock) disable iff (reset)
      cur_ff <= lng_ff)
      else $error("current run longer than best");

   // list never holds more than its depth
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(MAX_RUNS))
      else $error("tie count beyond list depth");

   // overflow only with a full list
   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> cnt_ff == CW'(MAX_RUNS))
      else $error("overflow set with list not full");

endmodule

// ===== rtl/longest_increasing_run_finder_top.sv =====
// Longest increasing run finder. Elements come in on the req_ beat channel, one
// signed 32-bit value per beat with a last flag. While a sequence streams in,
// req_ready stays high and one element is taken in every cycle with req_valid.
// After the beat flagged last, req_ready drops and the block plays out one rsp_
// beat per recorded longest run: start index, best length, run count, the
// ties_dropped flag and last_run on the final beat. Start indices are held in a
// small synchronous list memory; each result is read in S_READ and then shown
// in S_SHOW, so the next result is read only once the current one is taken.
// A stall on rsp_ready simply holds the current result and the read pointer.
// Once the final result beat is taken, the run state returns to its reset
// values and req_ready rises in the next cycle. Elements past MAX_LEN in one
// sequence are ignored for tracking, though their last flag still ends it.
// A synchronous reset returns to accepting elements with an empty list; no
// clearing pass is needed.
// depends on lir_pkg and lir_tracker
module longest_increasing_run_finder_top #(
   parameter int MAX_LEN  = lir_pkg::MAX_LEN_DEF,
   parameter int MAX_RUNS = lir_pkg::MAX_RUNS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  lir_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output lir_pkg::rsp_type rsp_data
);

   localparam int PW     = $clog2(MAX_LEN);
   localparam int LW     = $clog2(MAX_LEN+1);
   localparam int CW     = $clog2(MAX_RUNS+1);
   localparam int AW     = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
   localparam int StartW = lir_pkg::RUN_START_W;
   localparam int BestW  = lir_pkg::BEST_LEN_W;
   localparam int CountW = lir_pkg::RUN_COUNT_W;

   lir_pkg::state_type state_ff, state_in;
   logic [AW-1:0]      k_ff, k_in;
   logic [PW-1:0]      rd_ff;
   logic [PW-1:0]      list_mem [MAX_RUNS];
   logic               take;
   logic               clear;
   logic               last_k;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [PW-1:0]      wr_data;
   logic [LW-1:0]      longest;
   logic [CW-1:0]      count;
   logic               overflow;

   assign take = req_valid && req_ready;

   // run tracking
   lir_tracker #(
      .MAX_LEN  (MAX_LEN),
      .MAX_RUNS (MAX_RUNS)
   ) u_tracker (
      .clock    (clock),
      .reset    (reset),
      .take     (take),
      .value    (req_data.value),
      .clear    (clear),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .longest  (longest),
      .count    (count),
      .overflow (overflow)
   );

   // start index list, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         list_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == lir_pkg::S_READ) begin
         rd_ff <= list_mem[k_ff];
      end
   end

   // sequencer state and read pointer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lir_pkg::S_ACCUM;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
      end
   end

   assign last_k = (CW'(k_ff) + CW'(1)) == count;

   // next state: stream elements, then read and show each recorded start
   always_comb begin
      state_in  = state_ff;
      k_in      = k_ff;
      clear     = 1'b0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         lir_pkg::S_ACCUM: begin
            req_ready = 1'b1;
            if (req_valid && req_data.last_of_sequence) begin
               state_in = lir_pkg::S_READ;
               k_in     = '0;
            end
         end
         lir_pkg::S_READ: begin
            state_in = lir_pkg::S_SHOW;
         end
         lir_pkg::S_SHOW: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (last_k) begin
                  state_in = lir_pkg::S_ACCUM;
                  clear    = 1'b1;
               end else begin
                  k_in     = k_ff + AW'(1);
                  state_in = lir_pkg::S_READ;
               end
            end
         end
         default: begin
            state_in = lir_pkg::S_ACCUM;
         end
      endcase
   end

   // result beat fields, masked to their widths
   always_comb begin
      rsp_data.run_start    = StartW'(rd_ff);
      rsp_data.best_length  = BestW'(longest);
      rsp_data.run_count    = CountW'(count);
      rsp_data.ties_dropped = overflow;
      rsp_data.last_run     = last_k;
   end

   // input and output sides never open together
   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input and result sides active together");

   // playout only with a non-empty list
   a_count_nz: assert property (@(posedge clock) disable iff (reset)
      state_ff != lir_pkg::S_ACCUM |-> count != '0)
      else $error("playout with empty list");

   // read pointer stays inside the recorded entries
   a_k_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff != lir_pkg::S_ACCUM |-> CW'(k_ff) < count)
      else $error("read pointer past recorded runs");

   // final result hands back to the input side
   a_handback: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_data.last_run) |=> req_ready)
      else $error("no return to input after final result");

   // no list write during playout
   a_no_write: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> state_ff == lir_pkg::S_ACCUM)
      else $error("list write during playout");

endmodule
